@@ src/csvs_pkg.sv @@
// ============================================================================
// csvs_pkg: shared types and constants for the CSV line field splitter
// Holds the character codes, the quoting mode codes and the result record
// that the parse core hands to the output stage.
// ============================================================================
`default_nettype none

package csvs_pkg;

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // Quoting mode codes
    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_QUOTED = 2'd1;
    localparam logic [1:0] MODE_QSEEN  = 2'd2;

    // One result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       field_done;
        logic       line_done;
        logic [7:0] field_number;
        logic       quote_error;
    } result_t;

endpackage

`default_nettype wire

@@ src/csvs_parse_core.sv @@
// ============================================================================
// csvs_parse_core: quoting state and per-byte result logic
// Keeps the quoting mode, the field-empty flag and the field counter, and
// works out from one registered input beat whether a result is produced.
// State advances only when step is high.
// ============================================================================
`default_nettype none

module csvs_parse_core #(
    parameter int MAX_FIELDS = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        char_byte,
    input  wire logic              line_end,
    output logic                   res_valid,
    output csvs_pkg::result_t      result
);

    localparam int          LimitInt  = (MAX_FIELDS - 1 > 255) ? 255 : (MAX_FIELDS - 1);
    localparam logic [7:0]  CountLimit = 8'(LimitInt);

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic       empty_reg;
    logic       empty_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic       do_plain;

    // Compute next state and the result for this beat
    always_comb
    begin
        mode_next           = mode_reg;
        empty_next          = empty_reg;
        count_next          = count_reg;
        res_valid           = 1'b0;
        result              = '0;
        result.field_number = count_reg;
        do_plain            = 1'b0;

        if (line_end)
        begin
            // close the field and the line, flag an open quote
            res_valid          = 1'b1;
            result.field_done  = 1'b1;
            result.line_done   = 1'b1;
            result.quote_error = (mode_reg == csvs_pkg::MODE_QUOTED);
            mode_next          = csvs_pkg::MODE_PLAIN;
            empty_next         = 1'b1;
            count_next         = '0;
        end
        else
        begin
            case (mode_reg)
                csvs_pkg::MODE_QUOTED:
                begin
                    if (char_byte == csvs_pkg::CH_QUOTE)
                    begin
                        mode_next = csvs_pkg::MODE_QSEEN;
                    end
                    else
                    begin
                        res_valid       = 1'b1;
                        result.out_byte = char_byte;
                        empty_next      = 1'b0;
                    end
                end
                csvs_pkg::MODE_QSEEN:
                begin
                    if (char_byte == csvs_pkg::CH_QUOTE)
                    begin
                        // doubled quote: emit one literal quote
                        mode_next       = csvs_pkg::MODE_QUOTED;
                        res_valid       = 1'b1;
                        result.out_byte = csvs_pkg::CH_QUOTE;
                        empty_next      = 1'b0;
                    end
                    else
                    begin
                        do_plain = 1'b1;
                    end
                end
                default:
                begin
                    do_plain = 1'b1;
                end
            endcase

            if (do_plain)
            begin
                mode_next = csvs_pkg::MODE_PLAIN;
                if (char_byte == csvs_pkg::CH_COMMA)
                begin
                    // unquoted comma ends the field
                    res_valid         = 1'b1;
                    result.field_done = 1'b1;
                    empty_next        = 1'b1;
                    if (count_reg < CountLimit)
                    begin
                        count_next = count_reg + 8'd1;
                    end
                end
                else if (char_byte == csvs_pkg::CH_QUOTE && empty_reg)
                begin
                    mode_next = csvs_pkg::MODE_QUOTED;
                end
                else
                begin
                    res_valid       = 1'b1;
                    result.out_byte = char_byte;
                    empty_next      = 1'b0;
                end
            end
        end
    end

    // Advance state on each consumed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= csvs_pkg::MODE_PLAIN;
            empty_reg <= 1'b1;
            count_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            empty_reg <= empty_next;
            count_reg <= count_next;
        end
    end

    // Line end returns all state to its start values
    a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
        step && line_end |=> mode_reg == csvs_pkg::MODE_PLAIN && empty_reg && count_reg == '0)
        else $error("state not cleared after line end");

    // Field counter never passes its limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountLimit)
        else $error("field counter beyond limit");

    // A quote error only rides on the line-end result
    a_qerr_line: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result.quote_error |-> result.line_done && line_end)
        else $error("quote error outside line end");

    // A field end leaves an empty field behind
    a_field_empty: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && result.field_done |=> empty_reg)
        else $error("field not empty after field end");

endmodule

`default_nettype wire

@@ src/csvs_out_stage.sv @@
// ============================================================================
// csvs_out_stage: result register toward the master-side stream
// Holds one result beat until it is taken and reports whether a new beat
// can be loaded in the same cycle.
// ============================================================================
`default_nettype none

module csvs_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire csvs_pkg::result_t result,
    output logic                   can_load,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [15:0]            m_axis_tdata,  // out_byte [7:0], field_number [15:8]
    output logic [1:0]             m_axis_tuser,  // field_done [0], quote_error [1]
    output logic                   m_axis_tlast
);

    logic              valid_reg;
    logic              valid_next;
    csvs_pkg::result_t data_reg;

    assign can_load = !valid_reg || m_axis_tready;

    // Hold the beat until taken, refill on load
    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {data_reg.field_number, data_reg.out_byte};
    assign m_axis_tuser  = {data_reg.quote_error, data_reg.field_done};
    assign m_axis_tlast  = data_reg.line_done;

endmodule

`default_nettype wire

@@ src/csv_line_field_splitter.sv @@
// ============================================================================
// csv_line_field_splitter: CSV line splitter, one byte per beat
// Input register, quoting state logic and result register.
// ============================================================================
// Takes one beat per clock while ready is high: a raw byte (tlast low)
// or an end-of-line mark (tlast high). Each beat yields zero or one
// result; the beat waits in the input register until the result register
// has room, and its result is then loaded there; content bytes come out
// as data, an unquoted comma as a field end, and the end-of-line mark as
// a beat that closes the last field and the line and flags an unclosed
// quote. Quote bytes that only open or close quoting give no result.
// Sustained rate is one beat per cycle while the output is taken, with a
// combinational mode update between the input and result registers;
// ready drops only while the result register is full and not being taken.
`default_nettype none

module csv_line_field_splitter #(
    parameter int MAX_FIELDS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // char_byte [7:0]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // out_byte [7:0], field_number [15:8]
    output logic [1:0]       m_axis_tuser,   // field_done [0], quote_error [1]
    output logic             m_axis_tlast
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_end_reg;
    logic              can_load;
    logic              advance;
    logic              res_valid;
    csvs_pkg::result_t result;

    // Consume the held beat when the result register has room
    assign advance       = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Capture input payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
    end

    csvs_parse_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_byte (in_byte_reg),
        .line_end  (in_end_reg),
        .res_valid (res_valid),
        .result    (result)
    );

    csvs_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && res_valid),
        .result        (result),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
